// ===== rtl/cmpcal_pkg.sv =====
// ----------------------------------------------------------------------------
// cmpcal_pkg
// Shared types and constants for the compass heading calibration block.
// ----------------------------------------------------------------------------
package cmpcal_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int HEADING_W    = 12;
  localparam int ATAN_ENTRIES = 24;
  localparam int STEP_W       = 5;
  // CORDIC vector: centered value times 256, plus headroom for gain and sign.
  localparam int VEC_W        = 28;
  // Angle in degrees, Q16.
  localparam int ANG_W        = 27;
  // Heading scaled by ten, before the final shift by 16.
  localparam int SCL_W        = 30;
  localparam int CENTER_W     = SAMPLE_W + 2;

  localparam logic signed [SAMPLE_W-1:0]  LOW_RESET   = SAMPLE_W'(180);
  localparam logic signed [SAMPLE_W-1:0]  HIGH_RESET  = SAMPLE_W'(0);
  localparam logic signed [ANG_W-1:0]     ANG_HALF    = ANG_W'(180 * 65536);
  localparam logic [SCL_W-1:0]            ROUND_HALF  = SCL_W'(32768);
  localparam logic [HEADING_W-1:0]        HEAD_MAX    = HEADING_W'(3600);
  localparam logic [HEADING_W-1:0]        HEAD_ORIGIN = HEADING_W'(1800);

  typedef struct packed {
    logic              take_sample;
    logic              load_center;
    logic              cordic_step;
    logic              scale;
    logic              load_out;
    logic [STEP_W-1:0] step;
  } cmd_t;

  // atan(2^-i) in degrees, Q16, rounded to nearest.
  function automatic logic [21:0] atan_q16(input logic [STEP_W-1:0] idx);
    logic [21:0] v;
    unique case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/cmpcal_ifs.sv =====
// ----------------------------------------------------------------------------
// cmpcal_ifs
// Valid/ready channels for magnetometer samples and heading results.
// ----------------------------------------------------------------------------
interface cmpcal_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_raw;
  logic signed [15:0] y_raw;
  logic signed [15:0] z_raw;

  modport source (output valid, x_raw, y_raw, z_raw, input ready);
  modport sink   (input valid, x_raw, y_raw, z_raw, output ready);
endinterface

interface cmpcal_out_if;
  logic               valid;
  logic               ready;
  logic        [11:0] heading_tenths;
  logic signed [15:0] x_centered;
  logic signed [15:0] y_centered;
  logic signed [15:0] z_out;
  logic signed [15:0] min_x_out;
  logic signed [15:0] max_x_out;
  logic signed [15:0] min_y_out;
  logic signed [15:0] max_y_out;

  modport source (output valid, heading_tenths, x_centered, y_centered, z_out,
                  min_x_out, max_x_out, min_y_out, max_y_out, input ready);
  modport sink   (input valid, heading_tenths, x_centered, y_centered, z_out,
                  min_x_out, max_x_out, min_y_out, max_y_out, output ready);
endinterface

// ===== rtl/cmpcal_datapath.sv =====
// ----------------------------------------------------------------------------
// cmpcal_datapath
// Range tracking, centering, iterative CORDIC and heading scaling.
// ----------------------------------------------------------------------------
module cmpcal_datapath import cmpcal_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  cmd_t                        cmd,
  input  logic signed [SAMPLE_W-1:0]  x_raw,
  input  logic signed [SAMPLE_W-1:0]  y_raw,
  input  logic signed [SAMPLE_W-1:0]  z_raw,
  output logic        [HEADING_W-1:0] heading_tenths,
  output logic signed [SAMPLE_W-1:0]  x_centered,
  output logic signed [SAMPLE_W-1:0]  y_centered,
  output logic signed [SAMPLE_W-1:0]  z_out,
  output logic signed [SAMPLE_W-1:0]  min_x_out,
  output logic signed [SAMPLE_W-1:0]  max_x_out,
  output logic signed [SAMPLE_W-1:0]  min_y_out,
  output logic signed [SAMPLE_W-1:0]  max_y_out
);

  logic signed [SAMPLE_W-1:0] low_x, high_x, low_y, high_y;
  logic signed [SAMPLE_W-1:0] x_s, y_s, z_s;
  logic signed [SAMPLE_W-1:0] xc, yc;
  logic                       origin;
  logic signed [VEC_W-1:0]    vx, vy;
  logic signed [ANG_W-1:0]    ang;
  logic        [SCL_W-1:0]    scaled;

  logic signed [CENTER_W-1:0] twice_x, twice_y, adj_x, adj_y;
  logic signed [SAMPLE_W-1:0] xc_next, yc_next;
  logic signed [VEC_W-1:0]    vx_init, vy_init, vx_sh, vy_sh;
  logic signed [ANG_W-1:0]    ang_init, atan_val, t_ang;
  logic        [ANG_W-2:0]    t_mag;
  logic        [SCL_W-1:0]    scaled_next;
  logic        [SCL_W-17:0]   head_raw;
  logic        [HEADING_W-1:0] head_next;

  // Centering: (2v - (lo + hi)) / 2, truncated toward zero.
  always_comb begin
    twice_x = {x_s[SAMPLE_W-1], x_s, 1'b0}
            - ({{2{low_x[SAMPLE_W-1]}}, low_x} + {{2{high_x[SAMPLE_W-1]}}, high_x});
    twice_y = {y_s[SAMPLE_W-1], y_s, 1'b0}
            - ({{2{low_y[SAMPLE_W-1]}}, low_y} + {{2{high_y[SAMPLE_W-1]}}, high_y});
    adj_x   = twice_x + CENTER_W'(twice_x[CENTER_W-1]);
    adj_y   = twice_y + CENTER_W'(twice_y[CENTER_W-1]);
    xc_next = adj_x[SAMPLE_W:1];
    yc_next = adj_y[SAMPLE_W:1];
  end

  // A vector in the left half plane is turned by half a turn before CORDIC.
  always_comb begin
    vx_init  = {{(VEC_W-SAMPLE_W-8){xc_next[SAMPLE_W-1]}}, xc_next, 8'b0};
    vy_init  = {{(VEC_W-SAMPLE_W-8){yc_next[SAMPLE_W-1]}}, yc_next, 8'b0};
    ang_init = '0;
    if (xc_next[SAMPLE_W-1]) begin
      vx_init  = -vx_init;
      vy_init  = -vy_init;
      ang_init = yc_next[SAMPLE_W-1] ? -ANG_HALF : ANG_HALF;
    end
  end

  assign vx_sh    = vx >>> cmd.step;
  assign vy_sh    = vy >>> cmd.step;
  assign atan_val = ANG_W'(atan_q16(cmd.step));

  always_comb begin
    t_ang       = ang + ANG_HALF;
    t_mag       = t_ang[ANG_W-1] ? '0 : t_ang[ANG_W-2:0];
    scaled_next = (SCL_W'(t_mag) << 3) + (SCL_W'(t_mag) << 1) + ROUND_HALF;
  end

  always_comb begin
    head_raw = scaled[SCL_W-1:16];
    if (origin) begin
      head_next = HEAD_ORIGIN;
    end else if (head_raw > (SCL_W-16)'(HEAD_MAX)) begin
      head_next = HEAD_MAX;
    end else begin
      head_next = head_raw[HEADING_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_x  <= LOW_RESET;
      high_x <= HIGH_RESET;
      low_y  <= LOW_RESET;
      high_y <= HIGH_RESET;
    end else if (cmd.take_sample) begin
      if (x_raw < low_x)  low_x  <= x_raw;
      if (x_raw > high_x) high_x <= x_raw;
      if (y_raw < low_y)  low_y  <= y_raw;
      if (y_raw > high_y) high_y <= y_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      x_s <= x_raw;
      y_s <= y_raw;
      z_s <= z_raw;
    end
    if (cmd.load_center) begin
      xc     <= xc_next;
      yc     <= yc_next;
      origin <= (xc_next == '0) && (yc_next == '0);
      vx     <= vx_init;
      vy     <= vy_init;
      ang    <= ang_init;
    end else if (cmd.cordic_step) begin
      if (!vy[VEC_W-1]) begin
        vx  <= vx + vy_sh;
        vy  <= vy - vx_sh;
        ang <= ang + atan_val;
      end else begin
        vx  <= vx - vy_sh;
        vy  <= vy + vx_sh;
        ang <= ang - atan_val;
      end
    end
    if (cmd.scale) begin
      scaled <= scaled_next;
    end
    if (cmd.load_out) begin
      heading_tenths <= head_next;
      x_centered     <= xc;
      y_centered     <= yc;
      z_out          <= z_s;
      min_x_out      <= low_x;
      max_x_out      <= high_x;
      min_y_out      <= low_y;
      max_y_out      <= high_y;
    end
  end

endmodule

// ===== rtl/cmpcal_ctrl.sv =====
// ----------------------------------------------------------------------------
// cmpcal_ctrl
// Sequencer for one sample: capture, center, CORDIC iterations, scale, output.
// ----------------------------------------------------------------------------
module cmpcal_ctrl import cmpcal_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CENTER = 3'd1;
  localparam logic [2:0] S_ITER   = 3'd2;
  localparam logic [2:0] S_SCALE  = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_free;

  // The result register can take a new transaction once the old one has gone.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    step_next       = step;
    cmd             = '0;
    cmd.step        = step;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_sample = 1'b1;
          state_next      = S_CENTER;
        end
      end
      S_CENTER: begin
        cmd.load_center = 1'b1;
        step_next       = '0;
        state_next      = S_ITER;
      end
      S_ITER: begin
        cmd.cordic_step = 1'b1;
        step_next       = step + 1'b1;
        if (step == LAST_STEP) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/compass_heading_hard_iron_cal_top.sv =====
// ----------------------------------------------------------------------------
// compass_heading_hard_iron_cal_top
// Magnetometer heading with running min/max hard-iron calibration.
// ----------------------------------------------------------------------------
// Each sample transaction updates the tracked X/Y extremes, centers X and Y on
// the midpoint of their ranges and returns a heading of atan2(y, x) + 180
// degrees in tenths (0..3600, 1800 for a centered sample at the origin) along
// with the centered values, Z and the extremes. One sample is in work at a
// time and passes through these steps in order: capture, center, the
// CORDIC_STEPS iterations of the shared CORDIC rotator, scale, and the load
// of the result register, which waits until the old result has gone. The
// result register lets the next sample enter while a result waits on its sink.
// CORDIC_STEPS runs from 12 to 24; larger values act as 24.

module compass_heading_hard_iron_cal_top import cmpcal_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst,
  cmpcal_in_if.sink     sample,
  cmpcal_out_if.source  result
);

  localparam int EFF_STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  cmd_t cmd;

  cmpcal_ctrl #(
    .STEPS (EFF_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  cmpcal_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .x_raw          (sample.x_raw),
    .y_raw          (sample.y_raw),
    .z_raw          (sample.z_raw),
    .heading_tenths (result.heading_tenths),
    .x_centered     (result.x_centered),
    .y_centered     (result.y_centered),
    .z_out          (result.z_out),
    .min_x_out      (result.min_x_out),
    .max_x_out      (result.max_x_out),
    .min_y_out      (result.min_y_out),
    .max_y_out      (result.max_y_out)
  );

  // Only one sample is in work, so an accepted sample closes the input.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("input accepted while a sample was in work");

  // The sequencer issues at most one datapath command per cycle.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take_sample, cmd.load_center, cmd.cordic_step, cmd.scale,
              cmd.load_out}))
    else $error("overlapping datapath commands");

  // The heading is clamped to a full turn.
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.heading_tenths <= HEAD_MAX)
    else $error("heading out of range");

  // Once a sample has been taken in, both tracked ranges are ordered.
  a_range_ordered: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.min_x_out <= result.max_x_out)
                  && (result.min_y_out <= result.max_y_out))
    else $error("tracked minimum above maximum");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the compass heading calibration block.
// ----------------------------------------------------------------------------
// Magnetometer samples go in over the sample channel. A behavioral model in
// this file tracks the X/Y extremes, centers the sample, runs the same
// fixed-point CORDIC and queues the expected result. A monitor compares every
// result transaction with the oldest queued result, field by field. Sender
// gaps and sink stalls change from phase to phase.

module tb_top import cmpcal_pkg::*;;

  localparam int CORDIC_STEPS = 16;
  localparam int LATENCY = CORDIC_STEPS + 4;
  localparam int HEADING_ORIGIN = 1800;
  localparam int HEADING_FULL = 3600;
  localparam longint HALF_TURN_Q16 = 180 * 65536;
  localparam int SAMPLE_MIN = -32768;
  localparam int SAMPLE_MAX = 32767;
  localparam int GROWTH_ITEMS = 1100;

  typedef struct {
    logic        [HEADING_W-1:0] heading_tenths;
    logic signed [SAMPLE_W-1:0]  x_centered;
    logic signed [SAMPLE_W-1:0]  y_centered;
    logic signed [SAMPLE_W-1:0]  z_out;
    logic signed [SAMPLE_W-1:0]  min_x;
    logic signed [SAMPLE_W-1:0]  max_x;
    logic signed [SAMPLE_W-1:0]  min_y;
    logic signed [SAMPLE_W-1:0]  max_y;
  } heading_result_t;

  logic clk;
  logic rst;

  cmpcal_in_if  sample_ch ();
  cmpcal_out_if result_ch ();

  compass_heading_hard_iron_cal_top #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch)
  );

  heading_result_t pending_headings[$];

  // Calibration state of the model.
  int trk_lo_x;
  int trk_hi_x;
  int trk_lo_y;
  int trk_hi_y;

  int src_idle_pct;
  int snk_stall_pct;
  int sink_hold;
  int fail_count;
  int grown;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #8_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic longint atan_deg_q16(input int idx);
    case (idx)
      0:       return 2949120;
      1:       return 1740967;
      2:       return 919879;
      3:       return 466945;
      4:       return 234379;
      5:       return 117304;
      6:       return 58666;
      7:       return 29335;
      8:       return 14668;
      9:       return 7334;
      10:      return 3667;
      11:      return 1833;
      12:      return 917;
      13:      return 458;
      14:      return 229;
      15:      return 115;
      16:      return 57;
      17:      return 29;
      18:      return 14;
      19:      return 7;
      20:      return 4;
      21:      return 2;
      22:      return 1;
      default: return 0;
    endcase
  endfunction

  function automatic logic [HEADING_W-1:0] cordic_heading(input int xc, input int yc);
    longint vx;
    longint vy;
    longint nx;
    longint ny;
    longint ang;
    longint t;
    int     steps;
    int     i;
    if (xc == 0 && yc == 0) return HEADING_W'(HEADING_ORIGIN);
    vx = longint'(xc) * 256;
    vy = longint'(yc) * 256;
    ang = 0;
    // Fold the left half plane onto the right one and start from +/-180.
    if (xc < 0) begin
      ang = (yc >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
      vx = -vx;
      vy = -vy;
    end
    steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    for (i = 0; i < steps; i++) begin
      if (vy >= 0) begin
        nx = vx + (vy >>> i);
        ny = vy - (vx >>> i);
        ang += atan_deg_q16(i);
      end else begin
        nx = vx - (vy >>> i);
        ny = vy + (vx >>> i);
        ang -= atan_deg_q16(i);
      end
      vx = nx;
      vy = ny;
    end
    t = ang + HALF_TURN_Q16;
    if (t < 0) t = 0;
    t = (t * 10 + 32768) >>> 16;
    if (t > HEADING_FULL) t = HEADING_FULL;
    return t[HEADING_W-1:0];
  endfunction

  function automatic heading_result_t predict_heading(input int x, input int y, input int z);
    heading_result_t r;
    int              xc;
    int              yc;
    if (x > trk_hi_x) trk_hi_x = x;
    if (x < trk_lo_x) trk_lo_x = x;
    if (y > trk_hi_y) trk_hi_y = y;
    if (y < trk_lo_y) trk_lo_y = y;
    // Integer division truncates toward zero, as the block does.
    xc = (2 * x - (trk_lo_x + trk_hi_x)) / 2;
    yc = (2 * y - (trk_lo_y + trk_hi_y)) / 2;
    r.heading_tenths = cordic_heading(xc, yc);
    r.x_centered = xc[15:0];
    r.y_centered = yc[15:0];
    r.z_out = z[15:0];
    r.min_x = trk_lo_x[15:0];
    r.max_x = trk_hi_x[15:0];
    r.min_y = trk_lo_y[15:0];
    r.max_y = trk_hi_y[15:0];
    return r;
  endfunction

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int sat16(input int v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return v;
  endfunction

  task automatic report_field(input string name, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    fail_count++;
  endtask

  task automatic check_result();
    heading_result_t want;
    if (pending_headings.size() == 0) begin
      $display("%0t: unexpected result, heading %0d", $time, result_ch.heading_tenths);
      fail_count++;
    end else begin
      want = pending_headings.pop_front();
      if (result_ch.heading_tenths !== want.heading_tenths)
        report_field("heading_tenths", int'(want.heading_tenths),
                     int'(result_ch.heading_tenths));
      if (result_ch.x_centered !== want.x_centered)
        report_field("x_centered", int'(want.x_centered), int'(result_ch.x_centered));
      if (result_ch.y_centered !== want.y_centered)
        report_field("y_centered", int'(want.y_centered), int'(result_ch.y_centered));
      if (result_ch.z_out !== want.z_out)
        report_field("z_out", int'(want.z_out), int'(result_ch.z_out));
      if (result_ch.min_x_out !== want.min_x)
        report_field("min_x_out", int'(want.min_x), int'(result_ch.min_x_out));
      if (result_ch.max_x_out !== want.max_x)
        report_field("max_x_out", int'(want.max_x), int'(result_ch.max_x_out));
      if (result_ch.min_y_out !== want.min_y)
        report_field("min_y_out", int'(want.min_y), int'(result_ch.min_y_out));
      if (result_ch.max_y_out !== want.max_y)
        report_field("max_y_out", int'(want.max_y), int'(result_ch.max_y_out));
    end
  endtask

  // Result sink: checks each transaction and drives ready for the next edge.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) check_result();
      if (sink_hold > 0) begin
        result_ch.ready <= 1'b0;
        sink_hold--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic send_sample(input int x, input int y, input int z);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.x_raw <= x[15:0];
    sample_ch.y_raw <= y[15:0];
    sample_ch.z_raw <= z[15:0];
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    pending_headings.push_back(predict_heading(x, y, z));
  endtask

  task automatic wait_results_done();
    sample_ch.valid <= 1'b0;
    while (pending_headings.size() != 0) @(posedge clk);
  endtask

  // Mostly samples from the lowest value up to the given top; the rest sit near
  // the midpoint or on an axis, where the heading logic has its corner cases.
  task automatic pick_sample(input int top, output int x, output int y, output int z);
    int kind;
    int mid_x;
    int mid_y;
    mid_x = (trk_lo_x + trk_hi_x) >>> 1;
    mid_y = (trk_lo_y + trk_hi_y) >>> 1;
    kind = $urandom_range(99);
    if (kind < 60) begin
      x = rand_between(SAMPLE_MIN, top);
      y = rand_between(SAMPLE_MIN, top);
    end else if (kind < 85) begin
      x = sat16(mid_x + rand_between(-8, 8));
      y = sat16(mid_y + rand_between(-8, 8));
    end else if (kind < 93) begin
      x = rand_between(SAMPLE_MIN, top);
      y = mid_y;
    end else begin
      x = mid_x;
      y = rand_between(SAMPLE_MIN, top);
    end
    z = rand_between(SAMPLE_MIN, SAMPLE_MAX);
  endtask

  task automatic set_idling(input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_sample(90, 90, 0);          // first sample sits on its own midpoint
    send_sample(-100, -100, 1);
    send_sample(100, 100, -1);
    send_sample(0, 0, 21845);        // origin after the window opens
    send_sample(-100, 0, -21846);    // negative x on the axis gives full scale
    send_sample(-100, -1, 0);        // just below the axis, base angle -180
    send_sample(-100, 1, 0);
    send_sample(100, 0, 0);
    send_sample(0, 100, 0);
    send_sample(0, -100, 0);
    send_sample(100, 100, 0);
    send_sample(-100, 100, 0);
    send_sample(100, -100, 0);
    send_sample(-100, -100, 0);
    send_sample(3, -2, SAMPLE_MIN);
    send_sample(-2, 3, SAMPLE_MAX);
    send_sample(SAMPLE_MIN, 5, SAMPLE_MIN);
    send_sample(7, SAMPLE_MIN, SAMPLE_MAX);
    send_sample(SAMPLE_MIN, SAMPLE_MIN, 0);
    wait_results_done();
  endtask

  // The upper bound of the samples rises slowly, so the tracked maxima and
  // the midpoints keep moving through the run.
  task automatic test_growing_range(input int count, input int src_pct, input int snk_pct);
    int x;
    int y;
    int z;
    int top;
    int n;
    set_idling(src_pct, snk_pct);
    for (n = 0; n < count; n++) begin
      top = 100 + (grown * 32667) / GROWTH_ITEMS;
      if (top > SAMPLE_MAX - 1) top = SAMPLE_MAX - 1;
      pick_sample(top, x, y, z);
      send_sample(x, y, z);
      grown++;
    end
  endtask

  task automatic test_backpressure();
    int x;
    int y;
    int z;
    int n;
    set_idling(0, 0);
    sink_hold = 300;
    for (n = 0; n < 12; n++) begin
      pick_sample(trk_hi_x, x, y, z);
      send_sample(x, y, z);
    end
    wait_results_done();
  endtask

  task automatic test_sender_pause();
    int x;
    int y;
    int z;
    int n;
    set_idling(17, 17);
    for (n = 0; n < 20; n++) begin
      pick_sample(trk_hi_x, x, y, z);
      send_sample(x, y, z);
      if (n == 9) wait_results_done();
    end
    wait_results_done();
  endtask

  task automatic test_full_range();
    int x;
    int y;
    int z;
    int n;
    set_idling(0, 0);
    send_sample(SAMPLE_MAX, 0, 0);
    send_sample(0, SAMPLE_MAX, 0);
    send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    for (n = 0; n < 200; n++) begin
      case ((n / 50) % 4)
        0: set_idling(0, 0);
        1: set_idling(80, 0);
        2: set_idling(0, 80);
        default: set_idling(17, 17);
      endcase
      pick_sample(SAMPLE_MAX, x, y, z);
      send_sample(x, y, z);
    end
  endtask

  initial begin
    rst <= 1'b1;
    sample_ch.valid <= 1'b0;
    sample_ch.x_raw <= '0;
    sample_ch.y_raw <= '0;
    sample_ch.z_raw <= '0;
    trk_lo_x = 180;
    trk_hi_x = 0;
    trk_lo_y = 180;
    trk_hi_y = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    sink_hold = 0;
    fail_count = 0;
    grown = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_growing_range(260, 0, 0);
    test_growing_range(260, 80, 0);
    test_growing_range(260, 0, 80);
    test_growing_range(260, 17, 17);
    test_backpressure();
    test_sender_pause();
    test_full_range();

    wait_results_done();
    repeat (2 * LATENCY) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
